### rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/kdt_pkg.sv
package kdt_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CFG_WIDTH      = 32;
    localparam int IO_WIDTH       = 32;

    localparam logic [0:0] CFG_IDX_Q = 1'b0;
    localparam logic [0:0] CFG_IDX_R = 1'b1;

    localparam logic [CFG_WIDTH-1:0] Q_RESET = 32'd655;
    localparam logic [CFG_WIDTH-1:0] R_RESET = 32'd6554;

    // Datapath commands from the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,     // latch input item
        OP_RESET,    // reset item: load distance and 0.1 diagonal
        OP_PREDICT,  // predict state and covariance
        OP_SEED,     // seed on first measurement
        OP_S,        // innovation variance and innovation
        OP_DIV0,     // start gain divisions
        OP_MUL,      // issue a product (index in mul_sel)
        OP_APPLY     // write corrected state
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] mul_sel;
    } kdt_cmd_t;

    typedef struct packed {
        logic valid;
        logic is_reset;
        logic s_pos;
        logic div_done;
    } kdt_stat_t;

endpackage

### rtl/kalman_distance_tracker_top.sv
// Two-state constant-velocity distance tracker, signed Q16.16.
// Input channel: in_valid / in_stall with action, distance_in and
// measurement_valid. An item is taken when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall with distance_estimate; one result per
// item, taken when out_valid is high and out_stall low.
// Configuration: cfg_valid / cfg_ready with cfg_index (0 = process noise,
// 1 = measurement noise) and cfg_data; write only while idle.
// Sequence: a reset item loads the distance and returns its result; a process
// item without measurement predicts, then returns. A corrected item runs two
// serial gain divisions of DATA_WIDTH+FRAC_BITS steps each on one shared
// divider, then five products, then writes the corrected state.
// One item is worked at a time; in_stall stays high until the result is taken,
// so the next item can be accepted in the cycle after that.
// A stalled result holds; the block waits for out_stall to drop.
// Reset clears the state to position 2.0, zero velocity and covariance,
// unseeded, and restores the noise registers to their defaults.
module kalman_distance_tracker_top #(
    parameter int DATA_WIDTH = kdt_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = kdt_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                action,
    input  logic signed [kdt_pkg::IO_WIDTH-1:0] distance_in,
    input  logic                                measurement_valid,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [kdt_pkg::IO_WIDTH-1:0] distance_estimate,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [0:0]                          cfg_index,
    input  logic [kdt_pkg::CFG_WIDTH-1:0]       cfg_data
);
    import kdt_pkg::*;
    `include "assert_macros.svh"

    logic [CFG_WIDTH-1:0] q_reg, r_reg;
    logic                 in_fire, out_fire, busy;
    kdt_cmd_t             cmd;
    kdt_stat_t            stat;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy;
    assign in_fire   = in_valid && !busy;
    assign out_fire  = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= Q_RESET;
            r_reg <= R_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IDX_Q: q_reg <= cfg_data;
                CFG_IDX_R: r_reg <= cfg_data;
                default:   q_reg <= q_reg;
            endcase
        end
    end

    kdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_busy  (busy),
        .out_pend (out_valid),
        .out_fire (out_fire),
        .stat     (stat),
        .cmd      (cmd)
    );

    kdt_datapath #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .q_cfg     (q_reg),
        .r_cfg     (r_reg),
        .in_action (action),
        .in_dist   (distance_in),
        .in_valid  (measurement_valid),
        .est       (distance_estimate)
    );

    `ASSERT_IMPL(a_no_accept_while_out, out_valid, in_stall)
    `ASSERT_NEXT(a_accept_busy, in_fire, in_stall)
    `ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid && $stable(distance_estimate))

endmodule

### rtl/kdt_divider.sv
module kdt_divider #(
    parameter int DATA_WIDTH = kdt_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = kdt_pkg::FRAC_BITS_DEF,
    parameter int DEN_WIDTH  = kdt_pkg::DATA_WIDTH_DEF + 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DATA_WIDTH-1:0] num,
    input  logic        [DEN_WIDTH-1:0]  den,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] quot
);
    import kdt_pkg::*;

    localparam int STEPS = DATA_WIDTH + FRAC_BITS;
    localparam int CW    = $clog2(STEPS + 1);

    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic [STEPS-1:0]      sh_reg, sh_next;
    logic [DEN_WIDTH:0]    rem_reg, rem_next;
    logic [DATA_WIDTH:0]   q_reg, q_next;
    logic                  over_reg, over_next;
    logic                  neg_reg, neg_next;
    logic [DEN_WIDTH-1:0]  den_reg, den_next;
    logic [DEN_WIDTH:0]    trial;
    logic [DATA_WIDTH:0]   qs;
    logic [DATA_WIDTH:0]   lim;
    logic [DATA_WIDTH:0]   nmag;

    assign lim  = neg_reg ? ({1'b0, {DATA_WIDTH{1'b0}}} | ({{DATA_WIDTH{1'b0}}, 1'b1}
                  << (DATA_WIDTH-1)))
                          : (({{DATA_WIDTH{1'b0}}, 1'b1} << (DATA_WIDTH-1)) - 1'b1);
    assign nmag = num[DATA_WIDTH-1] ? -{num[DATA_WIDTH-1], num} : {1'b0, num};
    assign trial = {rem_reg[DEN_WIDTH-1:0], sh_reg[STEPS-1]};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        over_next = over_reg;
        neg_next  = neg_reg;
        den_next  = den_reg;
        qs        = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(STEPS);
            sh_next   = {nmag[DATA_WIDTH-1:0], {FRAC_BITS{1'b0}}};
            rem_next  = '0;
            q_next    = '0;
            over_next = 1'b0;
            neg_next  = num[DATA_WIDTH-1];
            den_next  = den;
        end
        else if (busy_reg)
        begin
            sh_next  = sh_reg << 1;
            rem_next = trial;
            if (!over_reg)
                qs = q_reg << 1;
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                if (!over_reg)
                    qs[0] = 1'b1;
            end
            q_next = qs;
            if (qs > lim)
                over_next = 1'b1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg   <= sh_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        over_reg <= over_next;
        neg_reg  <= neg_next;
        den_reg  <= den_next;
    end

    logic [DATA_WIDTH:0] qf;
    assign qf   = over_reg ? lim : q_reg;
    assign quot = neg_reg ? DATA_WIDTH'(-qf) : DATA_WIDTH'(qf);
    assign done = !busy_reg && !start;

endmodule

### rtl/kdt_datapath.sv
module kdt_datapath #(
    parameter int DATA_WIDTH = kdt_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = kdt_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  kdt_pkg::kdt_cmd_t                 cmd,
    output kdt_pkg::kdt_stat_t                stat,
    input  logic [kdt_pkg::CFG_WIDTH-1:0]     q_cfg,
    input  logic [kdt_pkg::CFG_WIDTH-1:0]     r_cfg,
    input  logic                              in_action,
    input  logic signed [kdt_pkg::IO_WIDTH-1:0] in_dist,
    input  logic                              in_valid,
    output logic signed [kdt_pkg::IO_WIDTH-1:0] est
);
    import kdt_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int XW = DATA_WIDTH + 36;  // room for exact sums with 32-bit regs
    localparam int MW = 2 * DATA_WIDTH;
    // a positive innovation variance fits the wider of state and register plus one bit
    localparam int SW = ((W > CFG_WIDTH) ? W : CFG_WIDTH) + 1;
    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
    localparam longint TENTH_L = ((longint'(1) << FRAC_BITS) + 5) / 10;
    localparam longint TWO_L   = longint'(2) << FRAC_BITS;

    function automatic logic signed [W-1:0] sat(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        begin
            hi = XW'(VMAX);
            lo = XW'(VMIN);
            if (x > hi)
                sat = VMAX;
            else if (x < lo)
                sat = VMIN;
            else
                sat = W'(x);
        end
    endfunction

    function automatic logic signed [XW-1:0] ext(input logic signed [W-1:0] x);
        ext = XW'(x);
    endfunction

    logic signed [W-1:0] pos_reg, vel_reg, p00_reg, p01_reg, p11_reg;
    logic                seeded_reg;
    logic                act_reg, mv_reg;
    logic signed [W-1:0] d_reg;
    logic signed [XW-1:0] s_reg;
    logic signed [W:0]   y_reg;
    logic signed [W-1:0] g0_reg, g1_reg;
    logic signed [W-1:0] m_reg [5];
    logic signed [XW-1:0] d_sat_src;
    logic signed [XW-1:0] qx, rx;

    assign qx = XW'($unsigned(q_cfg));
    assign rx = XW'($unsigned(r_cfg));
    assign d_sat_src = XW'(in_dist);

    // shared divider
    logic                div_start, div_sel_reg, div_done;
    logic signed [W-1:0] div_num, div_q;
    assign div_start = (cmd.op == OP_DIV0);
    assign div_num   = (cmd.mul_sel[0]) ? p01_reg : p00_reg;

    kdt_divider #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .DEN_WIDTH(SW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (SW'(s_reg)),
        .done  (div_done),
        .quot  (div_q)
    );

    // shared multiplier: signed magnitude, registered product
    logic signed [W:0]   ma, mb;
    logic [W:0]          ua, ub;
    logic [2*W+1:0]      prod;
    logic [2*W+1:0]      prod_reg;
    logic                mneg_reg;
    logic [2:0]          msel_reg;
    logic                mpend_reg;
    logic [2*W+1:0]      shp;
    logic [W:0]          mlim;
    logic signed [W-1:0] mres;

    always_comb
    begin
        case (cmd.mul_sel)
            3'd0:    begin ma = (W+1)'(g0_reg); mb = y_reg;           end
            3'd1:    begin ma = (W+1)'(g1_reg); mb = y_reg;           end
            3'd2:    begin ma = (W+1)'(g0_reg); mb = (W+1)'(p00_reg); end
            3'd3:    begin ma = (W+1)'(g0_reg); mb = (W+1)'(p01_reg); end
            default: begin ma = (W+1)'(g1_reg); mb = (W+1)'(p01_reg); end
        endcase
        ua = ma[W] ? (W+1)'(-ma) : (W+1)'(ma);
        ub = mb[W] ? (W+1)'(-mb) : (W+1)'(mb);
        prod = ua * ub;
    end

    assign shp  = prod_reg >> FRAC_BITS;
    assign mlim = mneg_reg ? (W+1)'(1) << (W-1) : ((W+1)'(1) << (W-1)) - 1'b1;
    always_comb
    begin
        logic [W:0] v;
        v = (shp > (2*W+2)'(mlim)) ? mlim : shp[W:0];
        mres = mneg_reg ? W'(-v) : W'(v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mpend_reg  <= 1'b0;
            pos_reg    <= sat(XW'(TWO_L));
            vel_reg    <= '0;
            p00_reg    <= '0;
            p01_reg    <= '0;
            p11_reg    <= '0;
            seeded_reg <= 1'b0;
            div_sel_reg <= 1'b0;
        end
        else
        begin
            mpend_reg <= (cmd.op == OP_MUL);
            if (cmd.op == OP_DIV0)
                div_sel_reg <= cmd.mul_sel[0];
            case (cmd.op)
                OP_RESET:
                begin
                    pos_reg    <= d_reg;
                    vel_reg    <= '0;
                    p00_reg    <= sat(XW'(TENTH_L));
                    p01_reg    <= '0;
                    p11_reg    <= sat(XW'(TENTH_L));
                    seeded_reg <= 1'b1;
                end
                OP_PREDICT:
                begin
                    pos_reg <= sat(ext(pos_reg) + ext(vel_reg));
                    p00_reg <= sat(ext(p00_reg) + (ext(p01_reg) <<< 1) + ext(p11_reg) + qx);
                    p01_reg <= sat(ext(p01_reg) + ext(p11_reg));
                    p11_reg <= sat(ext(p11_reg) + qx);
                end
                OP_SEED:
                begin
                    if (mv_reg && !seeded_reg)
                    begin
                        pos_reg    <= d_reg;
                        vel_reg    <= '0;
                        seeded_reg <= 1'b1;
                    end
                end
                OP_APPLY:
                begin
                    pos_reg <= sat(ext(pos_reg) + ext(m_reg[0]));
                    vel_reg <= sat(ext(vel_reg) + ext(m_reg[1]));
                    p00_reg <= sat(ext(p00_reg) - ext(m_reg[2]));
                    p01_reg <= sat(ext(p01_reg) - ext(m_reg[3]));
                    p11_reg <= sat(ext(p11_reg) - ext(m_reg[4]));
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            act_reg <= in_action;
            mv_reg  <= in_valid;
            d_reg   <= sat(d_sat_src);
        end
        if (cmd.op == OP_S)
        begin
            s_reg <= ext(p00_reg) + rx;
            y_reg <= (W+1)'(d_reg) - (W+1)'(pos_reg);
        end
        if (div_done && cmd.op == OP_NONE)
        begin
            if (div_sel_reg)
                g1_reg <= div_q;
            else
                g0_reg <= div_q;
        end
        if (cmd.op == OP_MUL)
        begin
            prod_reg <= prod;
            mneg_reg <= ma[W] ^ mb[W];
            msel_reg <= cmd.mul_sel;
        end
        if (mpend_reg)
            m_reg[msel_reg] <= mres;
    end

    logic signed [XW-1:0] px;
    assign px  = ext(pos_reg);
    assign est = (px > XW'(32'sh7fffffff)) ? 32'sh7fffffff :
                 (px < XW'(-64'sd2147483648)) ? 32'sh80000000 : IO_WIDTH'(pos_reg);

    assign stat.valid    = mv_reg;
    assign stat.is_reset = act_reg;
    assign stat.s_pos    = (s_reg > 0);
    assign stat.div_done = div_done;

endmodule

### rtl/kdt_ctrl.sv
module kdt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    output logic               in_busy,
    output logic               out_pend,
    input  logic               out_fire,
    input  kdt_pkg::kdt_stat_t stat,
    output kdt_pkg::kdt_cmd_t  cmd
);
    import kdt_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_PRED  = 4'd2;
    localparam logic [3:0] S_SEED  = 4'd3;
    localparam logic [3:0] S_S     = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_DIVW  = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_MULW  = 4'd9;
    localparam logic [3:0] S_APPLY = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [2:0] idx_reg, idx_next;
    logic       dstart_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd.op     = OP_NONE;
        cmd.mul_sel = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (stat.is_reset)
                begin
                    cmd.op     = OP_RESET;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op     = OP_PREDICT;
                    state_next = S_SEED;
                end
            end
            S_SEED:
            begin
                cmd.op     = OP_SEED;
                state_next = stat.valid ? S_S : S_OUT;
            end
            S_S:
            begin
                cmd.op     = OP_S;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                idx_next   = 3'd0;
                state_next = stat.s_pos ? S_DIV : S_OUT;
            end
            S_DIV:
            begin
                cmd.op     = OP_DIV0;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                // done rises once the division steps are through; the quotient is latched on OP_NONE
                if (stat.div_done && !dstart_reg)
                begin
                    if (idx_reg == 3'd0)
                    begin
                        idx_next   = 3'd1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        idx_next   = 3'd0;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = S_MULW;
            end
            S_MULW:
            begin
                if (idx_reg == 3'd4)
                    state_next = S_APPLY;
                else
                begin
                    idx_next   = idx_reg + 3'd1;
                    state_next = S_MUL;
                end
            end
            S_APPLY:
            begin
                cmd.op     = OP_APPLY;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_fire)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            dstart_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            dstart_reg <= (cmd.op == OP_DIV0);
        end
    end

    assign in_busy  = (state_reg != S_IDLE);
    assign out_pend = (state_reg == S_OUT);

endmodule
